### rtl/bsg_pkg.sv
`default_nettype none

package bsg_pkg;

  // Field widths fixed by the command format.
  localparam int REQ_W     = 3;
  localparam int DISP_W    = 24;
  localparam int FEED_W    = 16;
  localparam int SPM_W     = 12;
  localparam int CFG_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int PROD_W    = DISP_W + SPM_W;

  // Interval divider: a 26-bit constant dividend over a 28-bit divisor.
  localparam int QUOT_W    = 26;
  localparam int DIVISOR_W = 28;
  localparam int DCNT_W    = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] US_PER_MIN   = 26'd60000000;
  localparam logic [QUOT_W-1:0] MIN_INTERVAL = 26'd10;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

  // Start status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_FEED = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_STEPS_PER_MM = 1'b0;
  localparam logic CFG_MAX_FEED     = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DISP_W-1:0] move_dx;
    logic signed [DISP_W-1:0] move_dy;
    logic [FEED_W-1:0]        feed_rate;
  } in_item_t;

  typedef struct packed {
    logic                step_x;
    logic                step_y;
    logic                dir_x;
    logic                dir_y;
    logic                busy_res;
    logic                done_res;
    logic                drive_on;
    logic [STATUS_W-1:0] start_status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_MULF,
    S_CHECK,
    S_DIV,
    S_FINISH
  } bsg_state_t;

endpackage

`default_nettype wire

### rtl/bsg_divider.sv
`default_nettype none

module bsg_divider
  import bsg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output logic      [QUOT_W-1:0]    quotient,
  output div_stat_t                 stat
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [QUOT_W-1:0]    quo_r, quo_nxt;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(QUOT_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = US_PER_MIN;
    end else if (busy_r) begin
      rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, dvs_r}) : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[QUOT_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### rtl/two_axis_bresenham_step_generator_top.sv
// A tick, stop, enable, disable or clear beat goes from capture to the finish state, and
// its result is stored once the output is free; a start that runs the interval division
// makes three passes through one multiplier and then 26 restoring divider iterations.
// Throughput: one beat at a time; the next beat is taken the cycle after a result is stored.
// Reset (rst_n, synchronous, active low): idle, not moving, not done, drivers off,
// 80 steps per mm and a 6000 mm/min feed ceiling.
`default_nettype none

module two_axis_bresenham_step_generator_top
  import bsg_pkg::*;
#(
  parameter int STEP_BITS = 24,
  parameter int FRAC_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int ERR_W = STEP_BITS + 1;
  localparam logic [PROD_W-1:0] STEP_LIM = PROD_W'((64'd1 << STEP_BITS) - 64'd1);

  // Sequencer and captured beat.
  bsg_state_t state_r, state_nxt;
  in_item_t   in_r;

  // Configuration.
  logic [SPM_W-1:0]  spm_r;
  logic [FEED_W-1:0] max_feed_r;

  // Move state.
  logic [STEP_BITS-1:0] left_x_r, left_x_nxt;
  logic [STEP_BITS-1:0] left_y_r, left_y_nxt;
  logic [STEP_BITS-1:0] left_tot_r, left_tot_nxt;
  logic [STEP_BITS-1:0] major_tot_r, major_tot_nxt;
  logic [STEP_BITS-1:0] minor_tot_r, minor_tot_nxt;
  logic [ERR_W-1:0]     err_r, err_nxt;
  logic                 x_major_r, x_major_nxt;
  logic                 dir_x_r, dir_x_nxt;
  logic                 dir_y_r, dir_y_nxt;
  logic [QUOT_W-1:0]    interval_r, interval_nxt;
  logic [QUOT_W-1:0]    countdown_r, countdown_nxt;
  logic                 moving_r, moving_nxt;
  logic                 done_r, done_nxt;
  logic                 enabled_r, enabled_nxt;

  // Shared multiplier and step counts.
  logic [DISP_W-1:0]    mag_x, mag_y, mul_a;
  logic [PROD_W-1:0]    prod_r, prod_shift;
  logic [STEP_BITS-1:0] sat_steps;
  logic [STEP_BITS-1:0] nx_r, ny_r;
  logic [FEED_W-1:0]    feed_eff;

  // Control.
  logic         mul_en, div_start, commit, out_free, skip_div;
  div_stat_t    div_stat;
  logic [QUOT_W-1:0] quotient;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;

  // Bresenham temporaries.
  logic [ERR_W-1:0] err_sum;
  logic             minor_step;

  assign out_free = !out_valid_r || !out_stall;

  // Magnitudes of the displacements; the most negative value maps to 2^23.
  assign mag_x    = in_r.move_dx[DISP_W-1] ? (~in_r.move_dx + 1'b1) : in_r.move_dx;
  assign mag_y    = in_r.move_dy[DISP_W-1] ? (~in_r.move_dy + 1'b1) : in_r.move_dy;
  assign feed_eff = (in_r.feed_rate > max_feed_r) ? max_feed_r : in_r.feed_rate;
  assign skip_div = ((nx_r == '0) && (ny_r == '0)) || (feed_eff == '0);

  // Operand select for the one multiplier: x, then y, then the effective feed.
  always_comb begin
    unique case (state_r)
      S_MULX:  mul_a = mag_x;
      S_MULY:  mul_a = mag_y;
      default: mul_a = DISP_W'(feed_eff);
    endcase
  end

  // Step count: drop the fraction bits and saturate at the step width.
  assign prod_shift = prod_r >> FRAC_BITS;
  assign sat_steps  = (prod_shift > STEP_LIM) ? STEP_LIM[STEP_BITS-1:0]
                                              : prod_shift[STEP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(spm_r);
    end
    if (state_r == S_MULY) begin
      nx_r <= sat_steps;
    end
    if (state_r == S_MULF) begin
      ny_r <= sat_steps;
    end
  end

  bsg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (prod_r[DIVISOR_W-1:0]),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = ((in_data.req_type == REQ_START) && !moving_r) ? S_MULX : S_FINISH;
        end
      end
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_MULF;
      S_MULF:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = skip_div ? S_FINISH : S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    mul_en    = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      S_IDLE:                 in_stall  = 1'b0;
      S_MULX, S_MULY, S_MULF: mul_en    = 1'b1;
      S_CHECK:                div_start = !skip_div;
      S_FINISH:               commit    = out_free;
      default: ;
    endcase
  end

  // Effect of the captured beat on the move state, and its result.
  always_comb begin
    left_x_nxt    = left_x_r;
    left_y_nxt    = left_y_r;
    left_tot_nxt  = left_tot_r;
    major_tot_nxt = major_tot_r;
    minor_tot_nxt = minor_tot_r;
    err_nxt       = err_r;
    x_major_nxt   = x_major_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    interval_nxt  = interval_r;
    countdown_nxt = countdown_r;
    moving_nxt    = moving_r;
    done_nxt      = done_r;
    enabled_nxt   = enabled_r;
    res           = '0;
    err_sum       = err_r + ERR_W'(minor_tot_r);
    minor_step    = err_sum >= {1'b0, major_tot_r};

    case (in_r.req_type)
      REQ_TICK: begin
        if (moving_r) begin
          if (countdown_r > QUOT_W'(1)) begin
            countdown_nxt = countdown_r - QUOT_W'(1);
          end else begin
            err_nxt = minor_step ? (err_sum - {1'b0, major_tot_r}) : err_sum;
            if (x_major_r) begin
              res.step_x = 1'b1;
              res.step_y = minor_step;
            end else begin
              res.step_y = 1'b1;
              res.step_x = minor_step;
            end
            if (res.step_x && (left_x_r != '0)) begin
              left_x_nxt = left_x_r - STEP_BITS'(1);
            end
            if (res.step_y && (left_y_r != '0)) begin
              left_y_nxt = left_y_r - STEP_BITS'(1);
            end
            if (left_tot_r != '0) begin
              left_tot_nxt = left_tot_r - STEP_BITS'(1);
            end
            if (left_tot_nxt == '0) begin
              moving_nxt = 1'b0;
              done_nxt   = 1'b1;
            end else begin
              countdown_nxt = interval_r;
            end
          end
        end
      end
      REQ_START: begin
        if (moving_r) begin
          res.start_status = ST_BUSY;
        end else if ((nx_r == '0) && (ny_r == '0)) begin
          done_nxt = 1'b1;
        end else if (feed_eff == '0) begin
          res.start_status = ST_ZERO_FEED;
        end else begin
          dir_x_nxt     = !in_r.move_dx[DISP_W-1];
          dir_y_nxt     = !in_r.move_dy[DISP_W-1];
          left_x_nxt    = nx_r;
          left_y_nxt    = ny_r;
          x_major_nxt   = nx_r >= ny_r;
          major_tot_nxt = (nx_r >= ny_r) ? nx_r : ny_r;
          minor_tot_nxt = (nx_r >= ny_r) ? ny_r : nx_r;
          left_tot_nxt  = (nx_r >= ny_r) ? nx_r : ny_r;
          err_nxt       = '0;
          interval_nxt  = (quotient < MIN_INTERVAL) ? MIN_INTERVAL : quotient;
          countdown_nxt = (quotient < MIN_INTERVAL) ? MIN_INTERVAL : quotient;
          moving_nxt    = 1'b1;
          done_nxt      = 1'b0;
        end
      end
      REQ_STOP: moving_nxt = 1'b0;
      REQ_ENABLE: enabled_nxt = 1'b1;
      REQ_DISABLE: begin
        moving_nxt  = 1'b0;
        enabled_nxt = 1'b0;
      end
      REQ_CLEAR: done_nxt = 1'b0;
      default: ;
    endcase

    res.dir_x    = dir_x_nxt;
    res.dir_y    = dir_y_nxt;
    res.busy_res = moving_nxt;
    res.done_res = done_nxt;
    res.drive_on = enabled_nxt;
  end

  // Sequencer, configuration and move state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spm_r       <= 12'd80;
      max_feed_r  <= 16'd6000;
      left_x_r    <= '0;
      left_y_r    <= '0;
      left_tot_r  <= '0;
      major_tot_r <= '0;
      minor_tot_r <= '0;
      err_r       <= '0;
      x_major_r   <= 1'b1;
      dir_x_r     <= 1'b1;
      dir_y_r     <= 1'b1;
      interval_r  <= '0;
      countdown_r <= '0;
      moving_r    <= 1'b0;
      done_r      <= 1'b0;
      enabled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEPS_PER_MM: spm_r      <= cfg_wdata[SPM_W-1:0];
          CFG_MAX_FEED:     max_feed_r <= cfg_wdata[FEED_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        left_x_r    <= left_x_nxt;
        left_y_r    <= left_y_nxt;
        left_tot_r  <= left_tot_nxt;
        major_tot_r <= major_tot_nxt;
        minor_tot_r <= minor_tot_nxt;
        err_r       <= err_nxt;
        x_major_r   <= x_major_nxt;
        dir_x_r     <= dir_x_nxt;
        dir_y_r     <= dir_y_nxt;
        interval_r  <= interval_nxt;
        countdown_r <= countdown_nxt;
        moving_r    <= moving_nxt;
        done_r      <= done_nxt;
        enabled_r   <= enabled_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: the accepted beat and the stored result.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A running move always has a live countdown and steps left.
  a_countdown_live: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (countdown_r != '0))
    else $error("moving with a zero countdown");

  a_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (left_tot_r != '0))
    else $error("moving with no major steps left");

  // The Bresenham error stays below the major count.
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (err_r < {1'b0, major_tot_r}))
    else $error("Bresenham error out of range");

  // The divider only finishes while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  // A stored result is presented on the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid)
    else $error("result stored but not presented");

endmodule

`default_nettype wire
